/* hw/rtl/detd_pkg.sv */
package detd_pkg;

    localparam int ROLL_WIDTH_DEF = 32;
    localparam int TIME_WIDTH     = 13;
    localparam int POS_WIDTH      = 7;
    localparam int TS_WIDTH       = 58;
    localparam int CNT_WIDTH      = 32;
    localparam int WORD_WIDTH     = 32;

    localparam logic [TIME_WIDTH-1:0] STALE_HIGH = 13'd8191;

    typedef enum logic [1:0] {
        TYPE_XY       = 2'd0,
        TYPE_MINOR    = 2'd1,
        TYPE_XY_WAIT  = 2'd2,
        TYPE_MAJOR    = 2'd3
    } detd_type_t;

    typedef struct packed {
        logic                  has_event;
        logic [POS_WIDTH-1:0]  pos_x;
        logic [POS_WIDTH-1:0]  pos_y;
        logic [TS_WIDTH-1:0]   timestamp;
        logic                  from_time_word;
        logic [CNT_WIDTH-1:0]  event_index;
        logic [CNT_WIDTH-1:0]  bad_total;
        logic [CNT_WIDTH-1:0]  removed_total;
    } detd_result_t;

endpackage

/* hw/rtl/detd_in_stage.sv */
module detd_in_stage
    import detd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [WORD_WIDTH-1:0] event_word,
    input  logic                  advance,
    output logic                  fire,
    output logic [WORD_WIDTH-1:0] word
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [WORD_WIDTH-1:0] word_reg;

    assign in_ready = !valid_reg || advance;
    assign fire     = valid_reg && advance;
    assign word     = word_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= event_word;
        end
    end

endmodule

/* hw/rtl/detd_core.sv */
module detd_core
    import detd_pkg::*;
#(
    parameter int ROLL_WIDTH = ROLL_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic                  cfg_write_data,
    input  logic                  fire,
    input  logic [WORD_WIDTH-1:0] word,
    output detd_result_t          result
);

    localparam int STAMP_WIDTH = ROLL_WIDTH + 2 * TIME_WIDTH;

    logic                  remove_bad_reg;
    logic [TIME_WIDTH-1:0] time_low_reg,  time_low_next;
    logic [TIME_WIDTH-1:0] time_high_reg, time_high_next;
    logic [ROLL_WIDTH-1:0] roll_count_reg, roll_count_next;
    logic                  rollover_seen_reg, rollover_seen_next;
    logic                  awaiting_first_reg, awaiting_first_next;
    logic [POS_WIDTH-1:0]  held_x_reg, held_x_next;
    logic [POS_WIDTH-1:0]  held_y_reg, held_y_next;
    logic [CNT_WIDTH-1:0]  kept_count_reg, kept_count_next;
    logic [CNT_WIDTH-1:0]  bad_count_reg, bad_count_next;
    logic [CNT_WIDTH-1:0]  removed_count_reg, removed_count_next;

    logic [POS_WIDTH-1:0]   fx;
    logic [POS_WIDTH-1:0]   fy;
    logic [TIME_WIDTH-1:0]  ft;
    logic                   flag;
    detd_type_t             kind;
    logic [TIME_WIDTH-1:0]  stamp_high;
    logic [TIME_WIDTH-1:0]  stamp_low;
    logic [STAMP_WIDTH-1:0] stamp_wide;
    logic [TS_WIDTH-1:0]    stamp;

    assign fx   = ~word[6:0];
    assign fy   = word[14:8];
    assign ft   = word[28:16];
    assign flag = word[29];
    assign kind = detd_type_t'(word[31:30]);

    // a minor rollover word brings the high time, an xy word the low time
    assign stamp_high = (kind == TYPE_MINOR) ? ft : time_high_reg;
    assign stamp_low  = (kind == TYPE_XY) ? ft : time_low_reg;

    // roll count sits above the 26 bits of high and low time, no overlap
    assign stamp_wide = {roll_count_reg, stamp_high, stamp_low};

    generate
        if (STAMP_WIDTH >= TS_WIDTH)
        begin : g_stamp_trunc
            assign stamp = stamp_wide[TS_WIDTH-1:0];
        end
        else
        begin : g_stamp_ext
            assign stamp = {{(TS_WIDTH - STAMP_WIDTH){1'b0}}, stamp_wide};
        end
    endgenerate

    always_comb
    begin
        time_low_next       = time_low_reg;
        time_high_next      = time_high_reg;
        roll_count_next     = roll_count_reg;
        rollover_seen_next  = rollover_seen_reg;
        awaiting_first_next = awaiting_first_reg;
        held_x_next         = held_x_reg;
        held_y_next         = held_y_reg;
        kept_count_next     = kept_count_reg;
        bad_count_next      = bad_count_reg;
        removed_count_next  = removed_count_reg;
        result              = '0;

        if (remove_bad_reg && awaiting_first_reg && kind != TYPE_XY_WAIT)
        begin
            // leading words before the first xy-awaiting-time word
            bad_count_next     = bad_count_reg + 1'b1;
            removed_count_next = removed_count_reg + 1'b1;
        end
        else
        begin
            awaiting_first_next = 1'b0;
            unique case (kind)
                TYPE_XY:
                begin
                    if (remove_bad_reg && (word == '0 || flag))
                    begin
                        removed_count_next = removed_count_reg + 1'b1;
                    end
                    else
                    begin
                        time_low_next = ft;
                        if (remove_bad_reg && rollover_seen_reg &&
                            time_high_reg == STALE_HIGH)
                        begin
                            bad_count_next     = bad_count_reg + 1'b1;
                            removed_count_next = removed_count_reg + 1'b1;
                        end
                        else
                        begin
                            if (remove_bad_reg)
                            begin
                                rollover_seen_next = 1'b0;
                            end
                            result.has_event      = 1'b1;
                            result.pos_x          = fx;
                            result.pos_y          = fy;
                            result.from_time_word = 1'b0;
                            result.event_index    = kept_count_reg;
                            kept_count_next       = kept_count_reg + 1'b1;
                        end
                    end
                end
                TYPE_XY_WAIT:
                begin
                    held_x_next   = fx;
                    held_y_next   = fy;
                    time_low_next = ft;
                end
                TYPE_MINOR:
                begin
                    time_high_next        = ft;
                    result.has_event      = 1'b1;
                    result.pos_x          = held_x_reg;
                    result.pos_y          = held_y_reg;
                    result.from_time_word = 1'b1;
                    result.event_index    = kept_count_reg;
                    kept_count_next       = kept_count_reg + 1'b1;
                    if (flag)
                    begin
                        roll_count_next = '0;
                    end
                end
                TYPE_MAJOR:
                begin
                    rollover_seen_next = 1'b1;
                    // t0 mark clears the rollover count
                    if (flag)
                    begin
                        roll_count_next = '0;
                    end
                    else
                    begin
                        roll_count_next = roll_count_reg + 1'b1;
                    end
                end
                default:
                begin
                    roll_count_next = roll_count_reg;
                end
            endcase
        end

        if (result.has_event)
        begin
            result.timestamp = stamp;
        end
        result.bad_total     = bad_count_next;
        result.removed_total = removed_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remove_bad_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            remove_bad_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_low_reg       <= '0;
            time_high_reg      <= '0;
            roll_count_reg     <= '0;
            rollover_seen_reg  <= 1'b0;
            awaiting_first_reg <= 1'b1;
            held_x_reg         <= '0;
            held_y_reg         <= '0;
            kept_count_reg     <= '0;
            bad_count_reg      <= '0;
            removed_count_reg  <= '0;
        end
        else if (fire)
        begin
            time_low_reg       <= time_low_next;
            time_high_reg      <= time_high_next;
            roll_count_reg     <= roll_count_next;
            rollover_seen_reg  <= rollover_seen_next;
            awaiting_first_reg <= awaiting_first_next;
            held_x_reg         <= held_x_next;
            held_y_reg         <= held_y_next;
            kept_count_reg     <= kept_count_next;
            bad_count_reg      <= bad_count_next;
            removed_count_reg  <= removed_count_next;
        end
    end

endmodule

/* hw/rtl/detd_out_stage.sv */
module detd_out_stage
    import detd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  detd_result_t result,
    output logic         space,
    output logic         out_valid,
    input  logic         out_ready,
    output detd_result_t held
);

    logic         valid_reg;
    logic         valid_next;
    detd_result_t result_reg;

    assign space     = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign held      = result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

endmodule

/* hw/rtl/detector_event_time_decoder_top.sv */
// an accepted item is registered in the input register, decoded, then registered
// in the result register; a stalled output (out_ready low) holds it in between
// throughput: one item per cycle while the output is not stalled, limited only
// by the single decode pass between the input register and the result register
// reset (rst_n, async, active low) clears all decode state and counters,
// sets the awaiting-first flag and clears remove_bad
module detector_event_time_decoder_top
    import detd_pkg::*;
#(
    parameter int ROLL_WIDTH = ROLL_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic                  cfg_write_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [WORD_WIDTH-1:0] event_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  has_event,
    output logic [POS_WIDTH-1:0]  pos_x,
    output logic [POS_WIDTH-1:0]  pos_y,
    output logic [TS_WIDTH-1:0]   timestamp,
    output logic                  from_time_word,
    output logic [CNT_WIDTH-1:0]  event_index,
    output logic [CNT_WIDTH-1:0]  bad_total,
    output logic [CNT_WIDTH-1:0]  removed_total
);

    logic                  space;
    logic                  fire;
    logic [WORD_WIDTH-1:0] word;
    detd_result_t          result;
    detd_result_t          held;

    detd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .event_word (event_word),
        .advance    (space),
        .fire       (fire),
        .word       (word)
    );

    detd_core #(
        .ROLL_WIDTH (ROLL_WIDTH)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .fire           (fire),
        .word           (word),
        .result         (result)
    );

    detd_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .result    (result),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .held      (held)
    );

    assign has_event      = held.has_event;
    assign pos_x          = held.pos_x;
    assign pos_y          = held.pos_y;
    assign timestamp      = held.timestamp;
    assign from_time_word = held.from_time_word;
    assign event_index    = held.event_index;
    assign bad_total      = held.bad_total;
    assign removed_total  = held.removed_total;

endmodule

/* tb/testbench.sv */
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import detd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_WORDS = 240;
    localparam detd_result_t NONE = '0;

    typedef struct packed {
        logic         rb;
        logic [31:0]  word;
        logic         typed;
        detd_result_t want;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write_en = 1'b0;
    logic                  cfg_write_data = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [WORD_WIDTH-1:0] event_word = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  has_event;
    logic [POS_WIDTH-1:0]  pos_x;
    logic [POS_WIDTH-1:0]  pos_y;
    logic [TS_WIDTH-1:0]   timestamp;
    logic                  from_time_word;
    logic [CNT_WIDTH-1:0]  event_index;
    logic [CNT_WIDTH-1:0]  bad_total;
    logic [CNT_WIDTH-1:0]  removed_total;

    int unsigned idle_pct = 10;
    int unsigned fault_n = 0;
    int unsigned cycle_n = 0;

    // decoder state as the block should hold it
    logic                      rb_mode = 1'b0;
    logic [TIME_WIDTH-1:0]     t_low = '0;
    logic [TIME_WIDTH-1:0]     t_high = '0;
    logic [ROLL_WIDTH_DEF-1:0] roll = '0;
    logic                      roll_seen = 1'b0;
    logic                      wait_first = 1'b1;
    logic [POS_WIDTH-1:0]      hx = '0;
    logic [POS_WIDTH-1:0]      hy = '0;
    logic [CNT_WIDTH-1:0]      kept_n = '0;
    logic [CNT_WIDTH-1:0]      bad_n = '0;
    logic [CNT_WIDTH-1:0]      removed_n = '0;

    detd_result_t decoded_q[$];

    // {has_event, x, y, timestamp, from_time_word, index, bad, removed}
    dir_row_t dir_table [27] = '{
        // leading words before the first xy-wait word are dropped
        {1'b1, 32'h0000_0000, 1'b1, {1'b0, 7'd0, 7'd0, 58'd0, 1'b0, 32'd0, 32'd1, 32'd1}},
        {1'b1, 32'hE000_0000, 1'b1, {1'b0, 7'd0, 7'd0, 58'd0, 1'b0, 32'd0, 32'd2, 32'd2}},
        {1'b1, 32'h7FFF_FFFF, 1'b1, {1'b0, 7'd0, 7'd0, 58'd0, 1'b0, 32'd0, 32'd3, 32'd3}},
        {1'b1, 32'hBFFF_FF00, 1'b1, {1'b0, 7'd0, 7'd0, 58'd0, 1'b0, 32'd0, 32'd3, 32'd3}},
        {1'b1, 32'h4000_0000, 1'b1,
            {1'b1, 7'd127, 7'd127, 58'd8191, 1'b1, 32'd0, 32'd3, 32'd3}},
        // zero word, then pileup
        {1'b1, 32'h0000_0000, 1'b1, {1'b0, 7'd0, 7'd0, 58'd0, 1'b0, 32'd0, 32'd3, 32'd4}},
        {1'b1, 32'h2000_1234, 1'b1, {1'b0, 7'd0, 7'd0, 58'd0, 1'b0, 32'd0, 32'd3, 32'd5}},
        {1'b1, 32'h1FFF_FFFF, 1'b1,
            {1'b1, 7'd0, 7'd127, 58'd8191, 1'b0, 32'd1, 32'd3, 32'd5}},
        {1'b1, 32'h0000_0080, 1'b1,
            {1'b1, 7'd127, 7'd0, 58'd0, 1'b0, 32'd2, 32'd3, 32'd5}},
        {1'b1, 32'hC000_0000, 1'b0, NONE},
        {1'b1, 32'h0005_1122, 1'b0, NONE},
        {1'b1, 32'h5FFF_0000, 1'b0, NONE},
        // major rollover with high time 8191: xy words are stale until a minor rollover
        {1'b1, 32'hC000_0000, 1'b0, NONE},
        {1'b1, 32'h0010_0304, 1'b0, NONE},
        {1'b1, 32'h4005_0000, 1'b0, NONE},
        {1'b1, 32'h0ABC_DE01, 1'b0, NONE},
        // t0 marks on major and minor rollover
        {1'b1, 32'hE000_0000, 1'b0, NONE},
        {1'b1, 32'h6003_0000, 1'b0, NONE},
        {1'b1, 32'h8000_0000, 1'b0, NONE},
        {1'b1, 32'hC000_0000, 1'b0, NONE},
        {1'b1, 32'h2000_0001, 1'b0, NONE},
        // same cases with dropping off
        {1'b0, 32'h0000_0000, 1'b0, NONE},
        {1'b0, 32'h2000_00FF, 1'b0, NONE},
        {1'b0, 32'h5FFF_0000, 1'b0, NONE},
        {1'b0, 32'hC000_0000, 1'b0, NONE},
        {1'b0, 32'h0001_0000, 1'b0, NONE},
        {1'b0, 32'hAAAA_5555, 1'b0, NONE}
    };

    detector_event_time_decoder_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .event_word     (event_word),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .has_event      (has_event),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .timestamp      (timestamp),
        .from_time_word (from_time_word),
        .event_index    (event_index),
        .bad_total      (bad_total),
        .removed_total  (removed_total)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_n <= cycle_n + 1;
        if (cycle_n == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic detd_result_t emit_event(input logic [POS_WIDTH-1:0] x,
                                                input logic [POS_WIDTH-1:0] y,
                                                input logic ftw);
        detd_result_t r;
        logic [63:0]  sum;
        r = '0;
        sum = (64'(roll) << 26) + (64'(t_high) << 13) + 64'(t_low);
        r.has_event = 1'b1;
        r.pos_x = x;
        r.pos_y = y;
        r.timestamp = sum[TS_WIDTH-1:0];
        r.from_time_word = ftw;
        r.event_index = kept_n;
        kept_n = kept_n + 1;
        return r;
    endfunction

    function automatic detd_result_t decode_word(input logic [31:0] w);
        detd_result_t          r;
        logic [POS_WIDTH-1:0]  fx;
        logic [POS_WIDTH-1:0]  fy;
        logic [TIME_WIDTH-1:0] ft;
        logic                  flag;
        detd_type_t            kind;
        r = '0;
        fx = ~w[6:0];
        fy = w[14:8];
        ft = w[28:16];
        flag = w[29];
        kind = detd_type_t'(w[31:30]);
        if (rb_mode && wait_first && kind != TYPE_XY_WAIT)
        begin
            bad_n = bad_n + 1;
            removed_n = removed_n + 1;
        end
        else
        begin
            wait_first = 1'b0;
            case (kind)
                TYPE_XY:
                begin
                    if (rb_mode && (w == 32'd0 || flag))
                        removed_n = removed_n + 1;
                    else
                    begin
                        t_low = ft;
                        if (rb_mode && roll_seen && t_high == STALE_HIGH)
                        begin
                            bad_n = bad_n + 1;
                            removed_n = removed_n + 1;
                        end
                        else
                        begin
                            r = emit_event(fx, fy, 1'b0);
                            if (rb_mode)
                                roll_seen = 1'b0;
                        end
                    end
                end
                TYPE_XY_WAIT:
                begin
                    hx = fx;
                    hy = fy;
                    t_low = ft;
                end
                TYPE_MINOR:
                begin
                    t_high = ft;
                    r = emit_event(hx, hy, 1'b1);
                    if (flag)
                        roll = '0;
                end
                default:
                begin
                    roll = roll + 1;
                    roll_seen = 1'b1;
                    if (flag)
                        roll = '0;
                end
            endcase
        end
        r.bad_total = bad_n;
        r.removed_total = removed_n;
        return r;
    endfunction

    function automatic logic [TIME_WIDTH-1:0] pick_time();
        int unsigned sel;
        sel = $urandom_range(0, 5);
        if (sel == 0)
            return STALE_HIGH;
        else if (sel == 1)
            return '0;
        return TIME_WIDTH'($urandom);
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fault_n++;
        end
    endtask

    // waits until every decoded item has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_mode(input logic v);
        drain();
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        rb_mode = v;
    endtask

    task automatic send_word(input logic [31:0] w, input logic typed,
                             input detd_result_t want);
        detd_result_t r;
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        event_word <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        r = decode_word(w);
        decoded_q.push_back(typed ? want : r);
    endtask

    always @(posedge clk)
    begin : result_check
        detd_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (decoded_q.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual has_event %0b index %0h",
                         $time, has_event, event_index);
                fault_n++;
            end
            else
            begin
                want = decoded_q.pop_front();
                compare_field("has_event", 64'(want.has_event), 64'(has_event));
                compare_field("pos_x", 64'(want.pos_x), 64'(pos_x));
                compare_field("pos_y", 64'(want.pos_y), 64'(pos_y));
                compare_field("timestamp", 64'(want.timestamp), 64'(timestamp));
                compare_field("from_time_word", 64'(want.from_time_word),
                              64'(from_time_word));
                compare_field("event_index", 64'(want.event_index), 64'(event_index));
                compare_field("bad_total", 64'(want.bad_total), 64'(bad_total));
                compare_field("removed_total", 64'(want.removed_total),
                              64'(removed_total));
            end
        end
        out_ready <= (idle_pct == 0) || ($urandom_range(0, 99) >= idle_pct);
    end

    initial
    begin : stimulus
        int unsigned made;
        int unsigned sel;
        int          phase;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_table[i])
        begin
            if (i == 0 || dir_table[i].rb != rb_mode)
                set_mode(dir_table[i].rb);
            send_word(dir_table[i].word, dir_table[i].typed, dir_table[i].want);
        end

        for (phase = 0; phase < 3; phase++)
        begin
            set_mode(phase != 1);
            made = 0;
            while (made < RANDOM_WORDS)
            begin
                // back-to-back stretch in the middle phase
                idle_pct = (phase == 1 && made >= 60 && made < 180) ? 0 : 10;
                sel = $urandom_range(0, 99);
                if (sel < 40)
                begin
                    send_word({TYPE_XY_WAIT, 1'($urandom), pick_time(), 16'($urandom)},
                              1'b0, NONE);
                    send_word({TYPE_MINOR, $urandom_range(0, 15) == 0, pick_time(),
                               16'($urandom)}, 1'b0, NONE);
                    made += 2;
                end
                else
                begin
                    if (sel < 65)
                        send_word({TYPE_XY, 1'b0, pick_time(), 16'($urandom)}, 1'b0, NONE);
                    else if (sel < 75)
                        send_word({TYPE_MAJOR, $urandom_range(0, 15) == 0, pick_time(),
                                   16'($urandom)}, 1'b0, NONE);
                    else if (sel < 81)
                        send_word(32'd0, 1'b0, NONE);
                    else if (sel < 87)
                        send_word({TYPE_XY, 1'b1, pick_time(), 16'($urandom)}, 1'b0, NONE);
                    else
                        send_word($urandom, 1'b0, NONE);
                    made += 1;
                end
                // in the last phase, hold off until the pipe is empty if made lands on 120
                if (phase == 2 && made == 120)
                    drain();
            end
        end

        drain();
        repeat (4) @(posedge clk);
        if (fault_n == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
